@@ src/llah_pkg.sv @@
package llah_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = 26;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned WINDOW    = 1000;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned ITER_W    = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0]    WINDOW_CNT = CNT_W'(WINDOW);
  localparam logic [ITER_W-1:0]   LAST_ITER  = ITER_W'(DIV_STEPS - 1);
  localparam logic [SAMPLE_W-1:0] REF_RESET  = SAMPLE_W'(13107);
  localparam logic [SAMPLE_W-1:0] STEP_RESET = SAMPLE_W'(66);
  localparam logic [SAMPLE_W-1:0] AVG_RESET  = SAMPLE_W'(32768);

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_STEP = 1'b1;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_sample;
    logic start_div;
    logic step_div;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

@@ src/llah_if.sv @@
interface llah_in_if;
  import llah_pkg::*;

  logic    valid;
  logic    ready;
  sample_t light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink (input valid, input light_sample, output ready);
endinterface

interface llah_out_if;
  import llah_pkg::*;

  logic    valid;
  logic    ready;
  sample_t average_level;
  logic    trend_down;

  modport source (output valid, output average_level, output trend_down, input ready);
  modport sink (input valid, input average_level, input trend_down, output ready);
endinterface

@@ src/light_level_average_hysteresis.sv @@
// after an item is accepted, the update, divide and finish states run before its result is valid
// one item at a time: no new item is taken until the 26 step serial divider and finish are done
// an input item is accepted while an earlier result still waits at the output
// reset: async active low; sum and count cleared, average one half,
// threshold and reference level 13107, hysteresis step 66, trend up
module light_level_average_hysteresis (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  llah_in_if.sink              in_ch,
  llah_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  llah_pkg::cfg_idx_t   cfg_idx_i,
  input  llah_pkg::sample_t    cfg_data_i
);
  import llah_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  llah_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  llah_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .light_sample_i  (in_ch.light_sample),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .average_level_o (out_ch.average_level),
    .trend_down_o    (out_ch.trend_down)
  );

endmodule

@@ src/llah_ctrl.sv @@
module llah_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output llah_pkg::ctrl_cmd_t    cmd_o,
  input  llah_pkg::dp_status_t   status_i
);
  import llah_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_sample = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.start_div = 1'b1;
      end
      ST_DIVIDE: begin
        cmd_o.step_div = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/llah_datapath.sv @@
module llah_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  llah_pkg::sample_t      light_sample_i,
  input  logic                   cfg_we_i,
  input  llah_pkg::cfg_idx_t     cfg_idx_i,
  input  llah_pkg::sample_t      cfg_data_i,
  input  llah_pkg::ctrl_cmd_t    cmd_i,
  output llah_pkg::dp_status_t   status_o,
  output llah_pkg::sample_t      average_level_o,
  output logic                   trend_down_o
);
  import llah_pkg::*;

  sample_t           ref_q, step_q;
  sample_t           sample_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  sample_t           avg_q, avg_d;
  sample_t           thr_q, thr_d;
  logic              trend_q, trend_d;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [ITER_W-1:0] iter_q;

  logic              warm;
  logic [SUM_W-1:0]  sum_sub;
  logic [CNT_W:0]    trial, trial_diff;
  logic              trial_ge;
  logic [SAMPLE_W:0] band_hi;
  sample_t           band_hi_sat, band_lo_sat;

  // running sum and warm-up count
  always_comb begin
    warm    = count_q < WINDOW_CNT;
    sum_sub = warm ? '0 : {{(SUM_W-SAMPLE_W){1'b0}}, avg_q};
    sum_d   = sum_q - sum_sub + {{(SUM_W-SAMPLE_W){1'b0}}, sample_q};
    count_d = warm ? count_q + 1'b1 : WINDOW_CNT;
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial      = {rem_q, quo_q[SUM_W-1]};
    trial_diff = trial - {1'b0, count_q};
    trial_ge   = trial >= {1'b0, count_q};
  end

  assign status_o.div_last = iter_q == LAST_ITER;

  // saturate average, compare and move the band edge
  always_comb begin
    avg_d       = (|quo_q[SUM_W-1:SAMPLE_W]) ? '1 : quo_q[SAMPLE_W-1:0];
    trend_d     = avg_d > thr_q;
    band_hi     = {1'b0, ref_q} + {1'b0, step_q};
    band_hi_sat = band_hi[SAMPLE_W] ? '1 : band_hi[SAMPLE_W-1:0];
    band_lo_sat = (ref_q > step_q) ? ref_q - step_q : '0;
    thr_d       = trend_d ? band_hi_sat : band_lo_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= REF_RESET;
      step_q  <= STEP_RESET;
      sum_q   <= '0;
      count_q <= '0;
      avg_q   <= AVG_RESET;
      thr_q   <= REF_RESET;
      trend_q <= 1'b0;
      iter_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REFERENCE_LEVEL: ref_q  <= cfg_data_i;
          REG_HYSTERESIS_STEP: step_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.start_div) begin
        sum_q   <= sum_d;
        count_q <= count_d;
        iter_q  <= '0;
      end else if (cmd_i.step_div) begin
        iter_q <= iter_q + 1'b1;
      end
      if (cmd_i.finish) begin
        avg_q   <= avg_d;
        thr_q   <= thr_d;
        trend_q <= trend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= light_sample_i;
    end
    if (cmd_i.start_div) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end else if (cmd_i.step_div) begin
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
      rem_q <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign average_level_o = avg_q;
  assign trend_down_o    = trend_q;

endmodule

@@ src/llah_checker.sv @@
module llah_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input llah_pkg::sample_t   average_level_i,
  input logic                trend_down_i
);
  import llah_pkg::*;

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_i;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(average_level_i)
      && $stable(trend_down_i))
    else $error("stalled result changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input ready right after accept");

  // a new result only comes out of a busy phase
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while idle");

  // down means above a threshold, so never zero
  a_down_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && trend_down_i |-> average_level_i != '0)
    else $error("trend down with zero average");

endmodule

bind light_level_average_hysteresis llah_checker u_llah_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .average_level_i (out_ch.average_level),
  .trend_down_i    (out_ch.trend_down)
);

@@ test/light_average_checker.sv @@
`timescale 1ns / 1ps
module light_average_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  llah_in_if                  in_mon,
  llah_out_if                 out_mon,
  input  logic                cfg_we_i,
  input  llah_pkg::cfg_idx_t  cfg_idx_i,
  input  llah_pkg::sample_t   cfg_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);
  import llah_pkg::*;

  localparam int unsigned MAX_PRINTED = 100;

  typedef struct packed {
    sample_t average_level;
    logic    trend_down;
  } light_result_t;

  logic [SUM_W-1:0] level_sum;
  logic [CNT_W-1:0] sample_total;
  sample_t          avg_now;
  sample_t          band_edge;
  sample_t          ref_level;
  sample_t          hyst_step;
  logic             trend_now;
  light_result_t    expected_levels[$];

  task automatic report_mismatch(input string msg);
    if (mismatch_count_o < MAX_PRINTED) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_count_o++;
  endtask

  task automatic fold_sample(input sample_t sample, output light_result_t res);
    logic [SUM_W-1:0]    quotient;
    logic [SAMPLE_W:0]   upper;
    if (sample_total < WINDOW_CNT) begin
      level_sum    = level_sum + SUM_W'(sample);
      sample_total = sample_total + 1'b1;
      quotient     = level_sum / SUM_W'(sample_total);
    end else begin
      level_sum = level_sum - SUM_W'(avg_now) + SUM_W'(sample);
      quotient  = level_sum / SUM_W'(WINDOW);
    end
    avg_now = (quotient > SUM_W'(16'hFFFF)) ? 16'hFFFF : quotient[SAMPLE_W-1:0];
    // equal to the threshold counts as up
    if (avg_now > band_edge) begin
      trend_now = 1'b1;
      upper     = {1'b0, ref_level} + {1'b0, hyst_step};
      band_edge = upper[SAMPLE_W] ? '1 : upper[SAMPLE_W-1:0];
    end else begin
      trend_now = 1'b0;
      band_edge = (ref_level > hyst_step) ? ref_level - hyst_step : '0;
    end
    res.average_level = avg_now;
    res.trend_down    = trend_now;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    light_result_t fresh;
    light_result_t seen;
    light_result_t wanted;
    if (!rst_ni) begin
      ref_level        = REF_RESET;
      hyst_step        = STEP_RESET;
      level_sum        = '0;
      sample_total     = '0;
      avg_now          = AVG_RESET;
      band_edge        = REF_RESET;
      trend_now        = 1'b0;
      mismatch_count_o = 0;
      expected_levels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REFERENCE_LEVEL: ref_level = cfg_data_i;
          REG_HYSTERESIS_STEP: hyst_step = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        fold_sample(in_mon.light_sample, fresh);
        expected_levels.push_back(fresh);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.average_level = out_mon.average_level;
        seen.trend_down    = out_mon.trend_down;
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected item average_level %0d trend_down %0d",
                                    seen.average_level, seen.trend_down));
        end else begin
          wanted = expected_levels.pop_front();
          if (seen.average_level !== wanted.average_level) begin
            report_mismatch($sformatf("average_level got %0d expected %0d",
                                      seen.average_level, wanted.average_level));
          end
          if (seen.trend_down !== wanted.trend_down) begin
            report_mismatch($sformatf("trend_down got %0d expected %0d (average_level %0d)",
                                      seen.trend_down, wanted.trend_down,
                                      wanted.average_level));
          end
        end
      end
      pending_o <= expected_levels.size();
    end
  end

endmodule

@@ test/light_level_average_hysteresis_test.sv @@
`timescale 1ns / 1ps
module light_level_average_hysteresis_test;
  import llah_pkg::*;

  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS     = 85;
  localparam int unsigned OPENING_ITEMS   = 10;

  // first item lands exactly on the reset threshold
  localparam sample_t OPENING [OPENING_ITEMS] = '{
    16'd13107, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001,
    16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 16'hFFFE
  };

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  sample_t     cfg_data;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  bit          idling_on    = 1'b1;
  bit          hold_off_req = 1'b0;

  llah_in_if  in_ch ();
  llah_out_if out_ch ();

  light_level_average_hysteresis uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  light_average_checker average_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("light_level_average_hysteresis_test failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!idling_on || $urandom_range(3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(input sample_t s);
    in_ch.valid        <= 1'b1;
    in_ch.light_sample <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (idling_on && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input sample_t ref_val, input sample_t step_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_REFERENCE_LEVEL;
    cfg_data <= ref_val;
    @(posedge clk_i);
    cfg_idx  <= REG_HYSTERESIS_STEP;
    cfg_data <= step_val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic sample_t pick_sample(input int unsigned centre, input int unsigned span);
    int v;
    if ($urandom_range(7) == 0) begin
      return sample_t'($urandom);
    end
    v = int'(centre) + int'($urandom_range(2 * span)) - int'(span);
    if (v < 0) begin
      v = 0;
    end else if (v > 65535) begin
      v = 65535;
    end
    return sample_t'(v);
  endfunction

  initial begin
    sample_t     ref_pick;
    sample_t     step_pick;
    int unsigned centre;
    int unsigned span;
    in_ch.valid        = 1'b0;
    in_ch.light_sample = '0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_REFERENCE_LEVEL;
    cfg_data           = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < OPENING_ITEMS; i++) begin
      send_sample(OPENING[i]);
    end
    // band edges saturating at both ends of the scale
    wait_drained;
    write_regs(16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    wait_drained;
    write_regs(16'h0000, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'd100);
    send_sample(16'hFFFF);
    wait_drained;
    write_regs(16'hFFFF, 16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    wait_drained;
    write_regs(16'h0000, 16'hFFFF);
    send_sample(16'd12345);
    send_sample(16'hFFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained;
      if ($urandom_range(3) == 0) begin
        ref_pick = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end else begin
        ref_pick = sample_t'($urandom_range(65535));
      end
      step_pick = ($urandom_range(5) == 0) ? sample_t'($urandom_range(65535))
                                           : sample_t'($urandom_range(1500));
      write_regs(ref_pick, step_pick);
      centre    = $urandom_range(1) ? int'(ref_pick) : $urandom_range(65535);
      span      = $urandom_range(12000);
      idling_on = (p != RANDOM_PHASES - 1);
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_sample(pick_sample(centre, span));
    end

    wait_drained;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("light_level_average_hysteresis_test passed");
    end else begin
      $display("light_level_average_hysteresis_test failed");
    end
    $finish;
  end

endmodule

@@ light_level_average_hysteresis.f @@
src/llah_pkg.sv
src/llah_if.sv
src/llah_ctrl.sv
src/llah_datapath.sv
src/light_level_average_hysteresis.sv
src/llah_checker.sv
test/light_average_checker.sv
test/light_level_average_hysteresis_test.sv
